[rtl/core/xfrp_pkg.sv]
// ----------------------------------------------------------------------------
// xfrp_pkg
// Shared codes and controller/datapath interface types for the deframer.
// ----------------------------------------------------------------------------
package xfrp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam logic [7:0] MIN_LEN  = 8'd4;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_GOOD     = 3'd1;
  localparam logic [2:0] EV_BAD_HDR  = 3'd2;
  localparam logic [2:0] EV_BAD_LEN  = 3'd3;
  localparam logic [2:0] EV_BAD_CSUM = 3'd4;

  typedef struct packed {
    logic load;
    logic rd_hdr;
    logic rd_len;
    logic drop_hdr;
    logic drop_len;
    logic sum_start;
    logic sum_issue;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic hdr_ok;
    logic len_bad;
    logic len_short;
    logic sum_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/xor_frame_resync_parser_core.sv]
// ----------------------------------------------------------------------------
// xor_frame_resync_parser_core
// Header/length/XOR-checksum deframer: one received byte per beat in, one
// status result per beat out.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | rx_byte
//  out     | out_valid / out_ready| event_res, buttons, frame_length,
//          |                      | bad_header_total, bad_length_total,
//          |                      | bad_checksum_total
//
//  Each byte is stored, then checked: with fewer than two bytes held, on a bad
//  header, a bad length or an incomplete frame the check stops there; a complete
//  frame gets the XOR pass, which reads one byte a cycle through the store's single read port.
//  Reset (rst, synchronous) empties the store and clears the counters.
//  A finished result sits in the output register while the next byte is
//  taken; a stalled output holds the sequencer before it hands over.
// ----------------------------------------------------------------------------
module xor_frame_resync_parser_core #(
  parameter int BUF_BYTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  buttons,
  output logic [3:0]  frame_length,
  output logic [31:0] bad_header_total,
  output logic [31:0] bad_length_total,
  output logic [31:0] bad_checksum_total
);
  import xfrp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  xfrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xfrp_dp #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .rx_byte            (rx_byte),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .event_res          (event_res),
    .buttons            (buttons),
    .frame_length       (frame_length),
    .bad_header_total   (bad_header_total),
    .bad_length_total   (bad_length_total),
    .bad_checksum_total (bad_checksum_total)
  );

endmodule

[rtl/core/xfrp_ctrl.sv]
// ----------------------------------------------------------------------------
// xfrp_ctrl
// Sequencer: header check, length check, serial XOR pass, result hand-off.
// ----------------------------------------------------------------------------
module xfrp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  xfrp_pkg::sts_t sts,
  output xfrp_pkg::cmd_t cmd
);
  import xfrp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_HDR   = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_SUMW  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.few) begin
          state_next = S_EMIT;
        end else begin
          cmd.rd_hdr = 1'b1;
          state_next = S_HDR;
        end
      end
      S_HDR: begin
        if (!sts.hdr_ok) begin
          cmd.drop_hdr = 1'b1;
          state_next   = S_EMIT;
        end else begin
          cmd.rd_len = 1'b1;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (sts.len_bad) begin
          cmd.drop_len = 1'b1;
          state_next   = S_EMIT;
        end else if (sts.len_short) begin
          state_next = S_EMIT;
        end else begin
          cmd.sum_start = 1'b1;
          state_next    = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_issue = 1'b1;
        if (sts.sum_last) begin
          state_next = S_SUMW;
        end
      end
      S_SUMW: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/xfrp_dp.sv]
// ----------------------------------------------------------------------------
// xfrp_dp
// Circular frame store, fill/head pointers, XOR accumulator, error counters
// and the output register.
// ----------------------------------------------------------------------------
module xfrp_dp #(
  parameter int BUF_BYTES = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     rx_byte,
  input  xfrp_pkg::cmd_t cmd,
  output xfrp_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     event_res,
  output logic [7:0]     buttons,
  output logic [3:0]     frame_length,
  output logic [31:0]    bad_header_total,
  output logic [31:0]    bad_length_total,
  output logic [31:0]    bad_checksum_total
);
  import xfrp_pkg::*;

  localparam int PW = $clog2(BUF_BYTES);
  localparam int FW = $clog2(BUF_BYTES + 1);
  localparam int SW = PW + 1;

  logic [7:0]    store [BUF_BYTES];
  logic [7:0]    rdata;
  logic [PW-1:0] head;
  logic [FW-1:0] fill;
  logic [FW-1:0] len_q;
  logic [FW-1:0] idx;
  logic [FW-1:0] rd_idx;
  logic          pend;
  logic [7:0]    acc;
  logic [7:0]    btn_cap;
  logic          csum_ok;
  logic [2:0]    ev_q;
  logic [7:0]    btn_q;
  logic [3:0]    flen_q;
  logic [31:0]   hdr_cnt;
  logic [31:0]   len_cnt;
  logic [31:0]   csum_cnt;

  logic [SW-1:0] wr_sum;
  logic [SW-1:0] rd_off;
  logic [SW-1:0] rd_sum;
  logic [SW-1:0] adv;
  logic [SW-1:0] adv_sum;
  logic [PW-1:0] wr_addr;
  logic [PW-1:0] rd_addr;
  logic [PW-1:0] head_next;
  logic [FW+3:0] len_ext;
  logic          rd_en;
  logic          wr_en;

  assign wr_sum  = SW'(head) + SW'(fill);
  assign wr_addr = (wr_sum >= SW'(BUF_BYTES)) ? PW'(wr_sum - SW'(BUF_BYTES)) : PW'(wr_sum);
  assign wr_en   = cmd.load && (fill < FW'(BUF_BYTES));

  always_comb begin
    rd_off = '0;
    if (cmd.rd_len) begin
      rd_off = SW'(1);
    end else if (cmd.sum_issue) begin
      rd_off = SW'(idx);
    end
  end
  assign rd_sum  = SW'(head) + rd_off;
  assign rd_addr = (rd_sum >= SW'(BUF_BYTES)) ? PW'(rd_sum - SW'(BUF_BYTES)) : PW'(rd_sum);
  assign rd_en   = cmd.rd_hdr || cmd.rd_len || cmd.sum_issue;

  always_comb begin
    adv = SW'(len_q);
    if (cmd.drop_hdr) begin
      adv = SW'(1);
    end else if (cmd.drop_len) begin
      adv = SW'(2);
    end
  end
  assign adv_sum   = SW'(head) + adv;
  assign head_next = (adv_sum >= SW'(BUF_BYTES)) ? PW'(adv_sum - SW'(BUF_BYTES))
                                                 : PW'(adv_sum);
  assign len_ext   = {4'b0, len_q};

  assign sts.few       = (fill < FW'(2));
  assign sts.hdr_ok    = (rdata == HDR_BYTE);
  assign sts.len_bad   = (rdata < MIN_LEN) || ({1'b0, rdata} > 9'(BUF_BYTES));
  assign sts.len_short = ({1'b0, rdata} > 9'(fill));
  assign sts.sum_last  = (idx == len_q - FW'(1));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= rx_byte;
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      fill     <= '0;
      hdr_cnt  <= '0;
      len_cnt  <= '0;
      csum_cnt <= '0;
      pend     <= 1'b0;
    end else begin
      pend <= cmd.sum_issue;
      if (wr_en) begin
        fill <= fill + FW'(1);
      end
      if (cmd.drop_hdr) begin
        head    <= head_next;
        fill    <= fill - FW'(1);
        hdr_cnt <= hdr_cnt + 32'd1;
      end
      if (cmd.drop_len) begin
        head    <= head_next;
        fill    <= fill - FW'(2);
        len_cnt <= len_cnt + 32'd1;
      end
      if (cmd.finish) begin
        head <= head_next;
        fill <= fill - len_q;
        if (!csum_ok) begin
          csum_cnt <= csum_cnt + 32'd1;
        end
      end
    end
  end

  // serial XOR pass; last byte of the frame is the check byte
  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      len_q <= rdata[FW-1:0];
      idx   <= '0;
      acc   <= '0;
    end
    if (cmd.sum_issue) begin
      idx    <= idx + FW'(1);
      rd_idx <= idx;
    end
    if (pend) begin
      if (rd_idx == len_q - FW'(1)) begin
        csum_ok <= (rdata == acc);
      end else begin
        acc <= acc ^ rdata;
      end
      if (rd_idx == FW'(2)) begin
        btn_cap <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev_q   <= EV_NONE;
      btn_q  <= '0;
      flen_q <= '0;
    end
    if (cmd.drop_hdr) begin
      ev_q <= EV_BAD_HDR;
    end
    if (cmd.drop_len) begin
      ev_q <= EV_BAD_LEN;
    end
    if (cmd.finish) begin
      flen_q <= len_ext[3:0];
      if (csum_ok) begin
        ev_q  <= EV_GOOD;
        btn_q <= btn_cap;
      end else begin
        ev_q <= EV_BAD_CSUM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_res          <= ev_q;
      buttons            <= btn_q;
      frame_length       <= flen_q;
      bad_header_total   <= hdr_cnt;
      bad_length_total   <= len_cnt;
      bad_checksum_total <= csum_cnt;
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(BUF_BYTES))
    else $error("fill count beyond store size");

  a_hdr_step: assert property (@(posedge clk) disable iff (rst)
    cmd.drop_hdr |=> hdr_cnt == $past(hdr_cnt) + 32'd1)
    else $error("header error counter did not advance by one");

  a_rd_in_frame: assert property (@(posedge clk) disable iff (rst)
    pend |-> rd_idx < len_q)
    else $error("XOR pass read beyond frame");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result not presented after emit");

  a_finish_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> len_q <= fill)
    else $error("frame removed larger than fill");
`endif

endmodule

[tb/tb_xor_frame_resync_parser_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xor_frame_resync_parser_core
// Self-checking bench for the header/length/XOR deframer. A byte stream of
// directed frames, then mostly well-formed random frames mixed with noise,
// bad lengths and cut-short frames, is driven one beat at a time. Every byte
// is run through a local deframer model and the status it should produce is
// queued; each output beat is checked against the oldest queued status.
// ----------------------------------------------------------------------------
module tb_xor_frame_resync_parser_core;
  import xfrp_pkg::*;

  localparam int FRAME_BYTES = 12;
  localparam int TAIL_BEATS  = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1900;

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  btn;
    logic [3:0]  flen;
    logic [31:0] hdr_tot;
    logic [31:0] len_tot;
    logic [31:0] csum_tot;
  } link_status_t;

  typedef struct {
    logic [7:0] data;
    bit         hold;
  } rx_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  buttons;
  logic [3:0]  frame_length;
  logic [31:0] bad_header_total;
  logic [31:0] bad_length_total;
  logic [31:0] bad_checksum_total;

  rx_beat_t     rx_stream[$];
  link_status_t status_due[$];

  logic [7:0]  model_store[FRAME_BYTES];
  int unsigned model_fill;
  logic [31:0] model_hdr_errs;
  logic [31:0] model_len_errs;
  logic [31:0] model_csum_errs;

  int unsigned fail_count = 0;
  int unsigned idle_pct = 0;
  int unsigned beats_in = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned quiet_cycles = 0;

  xor_frame_resync_parser_core #(
    .BUF_BYTES(FRAME_BYTES)
  ) uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .event_res         (event_res),
    .buttons           (buttons),
    .frame_length      (frame_length),
    .bad_header_total  (bad_header_total),
    .bad_length_total  (bad_length_total),
    .bad_checksum_total(bad_checksum_total)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void drop_lead(int unsigned k);
    int i;
    for (i = 0; i < FRAME_BYTES; i++) begin
      model_store[i] = (i + k < FRAME_BYTES) ? model_store[i + k] : 8'h00;
    end
    model_fill = (k >= model_fill) ? 0 : model_fill - k;
  endfunction

  function automatic link_status_t deframe_byte(logic [7:0] b);
    link_status_t res;
    int unsigned  ln;
    logic [7:0]   acc;
    int           i;
    res = '0;
    res.ev = EV_NONE;
    if (model_fill < FRAME_BYTES) begin
      model_store[model_fill] = b;
      model_fill++;
    end
    if (model_fill >= 2) begin
      if (model_store[0] != HDR_BYTE) begin
        drop_lead(1);
        model_hdr_errs++;
        res.ev = EV_BAD_HDR;
      end else begin
        ln = {24'h0, model_store[1]};
        if (ln < MIN_LEN || ln > FRAME_BYTES) begin
          drop_lead(2);
          model_len_errs++;
          res.ev = EV_BAD_LEN;
        end else if (model_fill >= ln) begin
          acc = 8'h00;
          for (i = 0; i < ln - 1; i++) acc ^= model_store[i];
          if (model_store[ln - 1] == acc) begin
            res.ev = EV_GOOD;
            res.btn = model_store[2];
          end else begin
            model_csum_errs++;
            res.ev = EV_BAD_CSUM;
          end
          res.flen = ln[3:0];
          drop_lead(ln);
        end
      end
    end
    res.hdr_tot = model_hdr_errs;
    res.len_tot = model_len_errs;
    res.csum_tot = model_csum_errs;
    return res;
  endfunction

  task automatic queue_byte(logic [7:0] b, bit hold = 1'b0);
    rx_beat_t beat;
    beat.data = b;
    beat.hold = hold;
    rx_stream.push_back(beat);
  endtask

  // header, length, buttons, filler, then checksum (spoilt if csum_ok is 0)
  task automatic queue_frame(int unsigned len, logic [7:0] btn, bit csum_ok);
    logic [7:0] acc;
    logic [7:0] b;
    int unsigned i;
    acc = HDR_BYTE ^ len[7:0] ^ btn;
    queue_byte(HDR_BYTE);
    queue_byte(len[7:0]);
    queue_byte(btn);
    for (i = 3; i < len - 1; i++) begin
      b = 8'($urandom_range(0, 255));
      acc ^= b;
      queue_byte(b);
    end
    if (!csum_ok) acc ^= 8'($urandom_range(1, 255));
    queue_byte(acc);
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    int unsigned i;
    model_fill = 0;
    model_hdr_errs = '0;
    model_len_errs = '0;
    model_csum_errs = '0;
    for (i = 0; i < FRAME_BYTES; i++) model_store[i] = 8'h00;

    queue_frame(FRAME_BYTES, 8'hFF, 1'b1);
    queue_frame(4, 8'h00, 1'b1);
    queue_frame(4, 8'h5A, 1'b0);
    queue_byte(8'h00);
    queue_byte(HDR_BYTE);
    queue_byte(8'h03);
    queue_byte(HDR_BYTE);
    queue_byte(8'h0D);

    // first random beat waits for the pipe to empty
    queue_byte(8'hFF, 1'b1);
    while (rx_stream.size() < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (rx_stream.size() > 600 && rx_stream.size() < 640 && $urandom_range(0, 3) == 0)
        rx_stream[rx_stream.size() - 1].hold = 1'b1;
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(4, 8);
        queue_frame(len, 8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
      end else if (pick < 80) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        queue_byte(HDR_BYTE);
        queue_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                               : 8'($urandom_range(13, 255)));
      end else begin
        len = $urandom_range(4, 12);
        n = $urandom_range(0, len - 3);
        queue_byte(HDR_BYTE);
        queue_byte(len[7:0]);
        for (i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (rx_stream.size() != 0 || status_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // sender
  always @(posedge clk) begin : rx_driver
    logic       nv;
    logic [7:0] nd;
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= 8'h00;
    end else begin
      if (in_valid && in_ready) begin
        status_due.push_back(deframe_byte(rx_byte));
        void'(rx_stream.pop_front());
        beats_in++;
        if (beats_in % 100 == 0) begin
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 50;
          endcase
        end
      end
      nv = in_valid && !in_ready;
      nd = rx_byte;
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (rx_stream.size() > 0) begin
          if (rx_stream[0].hold && status_due.size() > 0) begin
            nv = 1'b0;
          end else if (rx_stream.size() > TAIL_BEATS && $urandom_range(0, 99) < idle_pct) begin
            tx_gap = $urandom_range(0, 9);
          end else begin
            nv = 1'b1;
            nd = rx_stream[0].data;
          end
        end
      end
      in_valid <= nv;
      rx_byte <= nd;
    end
  end

  // receiver and checker
  always @(posedge clk) begin : status_monitor
    link_status_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          $error("result beat with no status expected");
          fail_count++;
        end else begin
          want = status_due.pop_front();
          if (event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, event_res);
            fail_count++;
          end
          if (buttons !== want.btn) begin
            $error("buttons: expected %0h, got %0h", want.btn, buttons);
            fail_count++;
          end
          if (frame_length !== want.flen) begin
            $error("frame_length: expected %0d, got %0d", want.flen, frame_length);
            fail_count++;
          end
          if (bad_header_total !== want.hdr_tot) begin
            $error("bad_header_total: expected %0d, got %0d", want.hdr_tot, bad_header_total);
            fail_count++;
          end
          if (bad_length_total !== want.len_tot) begin
            $error("bad_length_total: expected %0d, got %0d", want.len_tot, bad_length_total);
            fail_count++;
          end
          if (bad_checksum_total !== want.csum_tot) begin
            $error("bad_checksum_total: expected %0d, got %0d", want.csum_tot,
                   bad_checksum_total);
            fail_count++;
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (rx_stream.size() > TAIL_BEATS && $urandom_range(0, 99) < idle_pct) begin
        rx_gap = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
